// ===== rtl/cba_pkg.sv =====
package cba_pkg;
  localparam int MaxWidth  = 256;
  localparam int ActDepth  = 1024;
  localparam int KRows     = 7;
  localparam int KCols     = 6;
  localparam int KTaps     = KRows * KCols;
  localparam int AddrShift = 20;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int ActW      = $clog2(ActDepth);
  localparam int AccW      = 40;

  localparam logic [1:0] MODE_PIXEL  = 2'd0;
  localparam logic [1:0] MODE_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_TABLE  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BIAS   = 2'd2;

  typedef struct packed {
    logic [9:0]      row;
    logic [7:0]      col;
    logic            last;
  } tag_t;

  // stage sideband carried alongside the cell chain
  typedef struct packed {
    logic            vld;
    tag_t            tag;
  } ctl_t;
endpackage

// ===== rtl/cba_if.sv =====
interface cba_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [9:0]         table_index;
  logic signed [15:0] value;
  modport source (output valid, mode, table_index, value, input ready);
  modport sink   (input valid, mode, table_index, value, output ready);
endinterface

interface cba_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_value;
  logic [9:0]         out_row;
  logic [7:0]         out_col;
  logic               frame_last;
  modport source (output valid, out_value, out_row, out_col, frame_last, input ready);
  modport sink   (input valid, out_value, out_row, out_col, frame_last, output ready);
endinterface

// ===== rtl/conv_6x7_bias_activate_core.sv =====
// Throughput: one pixel transaction per cycle, back to back, unless the
// output register is full and not taken. A weight or table load waits
// while a result-producing pixel is in flight.
// The pipe advances as a whole and holds when the output register is full
// and not taken. Reset (rst_n low, synchronous) clears the counters, window,
// valid flags and registers (width 32, height 32, bias 0); stores undefined.
module conv_6x7_bias_activate_core import cba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  cba_in_if.sink      in_ch,
  cba_out_if.source   out_ch
);
  localparam int Lat = 2 * KTaps + 1; // stage-2 to table read, chain depth

  logic [8:0]        width_r;
  logic [9:0]        height_r;
  logic signed [15:0] bias_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd32; height_r <= 10'd32; bias_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[8:0];
        CFG_HEIGHT: height_r <= cfg_data[9:0];
        CFG_BIAS:   bias_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe advance: whole pipe moves unless the output register is stuck
  logic out_vld_r, adv;
  assign adv = !out_vld_r || out_ch.ready;
  logic [1:0] mode;
  assign mode = in_ch.mode;
  // loads wait until no result-producing pixel is in flight, so each pixel
  // sees the weights and table current at its acceptance
  logic [6:0] inflight_r;
  logic load_hold;
  assign load_hold = (mode == MODE_WEIGHT || mode == MODE_TABLE) && inflight_r != 7'd0;
  assign in_ch.ready = adv && !load_hold;
  logic acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;
  logic pix_go;
  assign pix_go = acc_in && mode == MODE_PIXEL;

  // weights: 42 registers, each at a fixed cell
  logic signed [15:0] wt_r [KTaps];
  always_ff @(posedge clk) begin
    if (acc_in && mode == MODE_WEIGHT && in_ch.table_index < 10'(KTaps))
      wt_r[in_ch.table_index[5:0]] <= in_ch.value;
  end

  // raster counters
  logic [9:0] row_r;
  logic [7:0] col_r;
  logic [8:0] w_eff;
  logic [9:0] h_eff;
  always_comb begin
    w_eff = (width_r == 0) ? 9'd1 : (width_r > 9'(MaxWidth) ? 9'(MaxWidth) : width_r);
    h_eff = (height_r == 0) ? 10'd1 : height_r;
  end
  logic col_end, row_end;
  assign col_end = {1'b0, col_r} >= w_eff - 9'd1;
  assign row_end = row_r >= h_eff - 10'd1;
  // full window present for this pixel
  logic pix_out;
  assign pix_out = row_r >= 10'd6 && col_r >= 8'd5 && w_eff >= 9'd6 && h_eff >= 10'd7;

  // line store: six rows, one RAM per row; read column col, write it back.
  // slot_r tracks row mod 6.
  logic signed [15:0] ls_q [KRows-1];
  logic [2:0] slot_r;
  // registered read: request at acceptance, data next cycle. Pixel stage 1
  // holds the new pixel and the slot rotation.
  logic         s1_vld_r;
  logic [2:0]   s1_slot_r;
  logic signed [15:0] s1_pix_r;
  tag_t         s1_tag_r;
  logic         s1_out_r;
  for (genvar k = 0; k < KRows - 1; k++) begin : g_ls
    cba_ram #(.Width(16), .Depth(MaxWidth)) u_ls (
      .clk, .we(pix_go && slot_r == 3'(k)), .waddr(col_r[ColW-1:0]),
      .wdata(in_ch.value), .re(pix_go), .raddr(col_r[ColW-1:0]), .rdata(ls_q[k]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; slot_r <= '0; s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= pix_go;
      if (pix_go) begin
        if (col_end) begin
          col_r  <= '0;
          row_r  <= row_end ? 10'd0 : row_r + 10'd1;
          slot_r <= (row_end || slot_r == 3'd5) ? 3'd0 : slot_r + 3'd1;
        end else col_r <= col_r + 8'd1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv && pix_go) begin
      s1_slot_r <= slot_r;
      s1_pix_r  <= in_ch.value;
      s1_tag_r  <= '{row: row_r - 10'd6, col: col_r - 8'd5, last: row_end && col_end};
      s1_out_r  <= pix_out;
    end
  end

  // window: shift left on each pixel, new column from the line store,
  // oldest stored row first
  logic signed [15:0] win_r [KTaps];
  logic signed [15:0] newcol [KRows];
  always_comb begin
    for (int k = 0; k < KRows - 1; k++) begin
      logic [3:0] s;
      s = 4'(s1_slot_r) + 4'(k);
      if (s >= 4'd6) s = s - 4'd6;
      newcol[k] = ls_q[s[2:0]];
    end
    newcol[KRows-1] = s1_pix_r;
  end
  logic win_go;
  assign win_go = adv && s1_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KTaps; i++) win_r[i] <= '0;
    end else if (win_go) begin
      for (int r = 0; r < KRows; r++) begin
        for (int c = 0; c < KCols - 1; c++) win_r[r*KCols+c] <= win_r[r*KCols+c+1];
        win_r[r*KCols+KCols-1] <= newcol[r];
      end
    end
  end

  // stage 2: snapshot the window for the chain; tap k enters cell k at its
  // time slot via a per-tap delay line (skew) so the chain stays systolic.
  ctl_t s2_r;
  logic signed [15:0] snap_r [KTaps];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_r.vld <= 1'b0;
    else if (adv) s2_r.vld <= s1_vld_r && s1_out_r;
    if (adv) s2_r.tag <= s1_tag_r;
  end
  // window registers update on win_go; the snapshot is the post-update window
  // which appears in the cycle after win_go, so snap uses win_r at stage 2.
  // Cell k sees the window value through its own delay line dly.
  logic signed [AccW-1:0] chain [KTaps+1];
  logic signed [AccW-1:0] seed_r;
  always_ff @(posedge clk) if (adv) seed_r <= AccW'(bias_r) <<< 13;
  assign chain[0] = seed_r;
  for (genvar k = 0; k < KTaps; k++) begin : g_cell
    logic signed [15:0] dly [2*k+1];
    always_ff @(posedge clk) begin
      if (adv) begin
        dly[0] <= win_r[k];
        for (int j = 1; j <= 2*k; j++) dly[j] <= dly[j-1];
      end
    end
    assign snap_r[k] = dly[2*k];
    cba_cell u_cell (.clk, .en(adv), .weight(wt_r[k]), .pixel(snap_r[k]),
                     .sum_in(chain[k]), .sum_out(chain[k+1]));
  end

  // control shadow of the chain
  ctl_t ctl_r [Lat];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) ctl_r[i].vld <= 1'b0;
    end else if (adv) begin
      ctl_r[0].vld <= s2_r.vld;
      for (int i = 1; i < Lat; i++) ctl_r[i].vld <= ctl_r[i-1].vld;
    end
    if (adv) begin
      ctl_r[0].tag <= s2_r.tag;
      for (int i = 1; i < Lat; i++) ctl_r[i].tag <= ctl_r[i-1].tag;
    end
  end

  // result-producing pixels between acceptance and the table read
  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_r + 7'(pix_go && pix_out) - 7'(adv && ctl_r[Lat-1].vld);
  end

  // address stage
  logic signed [AccW-1:0] off;
  logic [ActW-1:0] addr;
  always_comb begin
    off = chain[KTaps] + (AccW'(ActDepth / 2) <<< AddrShift);
    if (off < 0) addr = '0;
    else if ((off >>> AddrShift) > AccW'(ActDepth - 1)) addr = ActW'(ActDepth - 1);
    else addr = off[AddrShift +: ActW];
  end

  logic [15:0] act_q;
  cba_ram #(.Width(16), .Depth(ActDepth)) u_act (
    .clk, .we(acc_in && mode == MODE_TABLE && {1'b0, in_ch.table_index} < 11'(ActDepth)),
    .waddr(in_ch.table_index[ActW-1:0]), .wdata(in_ch.value),
    .re(adv), .raddr(addr), .rdata(act_q));

  tag_t out_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= ctl_r[Lat-1].vld;
  end
  always_ff @(posedge clk) if (adv) out_tag_r <= ctl_r[Lat-1].tag;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_value  = act_q;
  assign out_ch.out_row    = out_tag_r.row;
  assign out_ch.out_col    = out_tag_r.col;
  assign out_ch.frame_last = out_tag_r.last;
endmodule

// ===== rtl/cba_ram.sv =====
module cba_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cba_cell.sv =====
// One MAC cell of the systolic sum chain: adds one tap product to the partial
// sum handed in by its left neighbor. Product is registered before the add.
module cba_cell import cba_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [15:0]     weight,
  input  logic signed [15:0]     pixel,
  input  logic signed [AccW-1:0] sum_in,
  output logic signed [AccW-1:0] sum_out
);
  logic signed [31:0]     prod_r;
  logic signed [AccW-1:0] sum_d_r;
  logic signed [AccW-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= weight * pixel;
      sum_d_r <= sum_in;
      sum_r   <= sum_d_r + AccW'(prod_r);
    end
  end
  assign sum_out = sum_r;
endmodule
